// ===== sv/image_scale_by_two_defines.svh =====
// -----------------------------------------------------------------------------
// Image scale by two: assertion macros
// Clocked assertion helpers used by the top level to check this block.
// -----------------------------------------------------------------------------
`ifndef IMAGE_SCALE_BY_TWO_DEFINES_SVH
`define IMAGE_SCALE_BY_TWO_DEFINES_SVH

// Check on every clock edge outside reset.
`define ISB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ISB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/isb_pkg.sv =====
// -----------------------------------------------------------------------------
// Image scale by two: package
// Widths, register indexes, modes and the command word passed front to back.
// -----------------------------------------------------------------------------
package isb_pkg;

  localparam int PIX_W          = 8;
  localparam int COORD_W        = 11;
  localparam int CFG_W          = 11;
  localparam int CFG_IDX_W      = 2;
  localparam int PAIR_W         = 9;
  localparam int QUEUE_DEPTH    = 2;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_MODE   = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } isb_reg_e;

  typedef enum logic {
    MODE_UP   = 1'b0,
    MODE_DOWN = 1'b1
  } isb_mode_e;

  typedef struct packed {
    isb_mode_e          mode;
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } isb_cmd_t;

endpackage

// ===== sv/isb_queue.sv =====
// -----------------------------------------------------------------------------
// Image scale by two: command queue
// Short FIFO of command words between the front and the back.
// -----------------------------------------------------------------------------
module isb_queue import isb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  isb_cmd_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output isb_cmd_t data_o,
  output logic     empty_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  isb_cmd_t          mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/isb_front.sv =====
// -----------------------------------------------------------------------------
// Image scale by two: front
// Holds configuration, tracks the source position, pairs pixels through the
// line buffer and issues one command word per input that yields results.
// -----------------------------------------------------------------------------
module isb_front import isb_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 push_i,
  input  logic [PIX_W-1:0]     pixel_in_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output isb_cmd_t             q_cmd_o
);

  localparam int ColW      = $clog2(MAX_WIDTH);
  localparam int RowW      = $clog2(MAX_HEIGHT);
  localparam int EffWW     = $clog2(MAX_WIDTH + 1);
  localparam int EffHW     = $clog2(MAX_HEIGHT + 1);
  localparam int CmpWW     = (EffWW > CFG_W) ? EffWW : CFG_W;
  localparam int CmpHW     = (EffHW > CFG_W) ? EffHW : CFG_W;
  localparam int LineDepth = MAX_WIDTH / 2 + 1;
  localparam int LineAw    = $clog2(LineDepth);

  isb_mode_e           mode_q;
  logic [CFG_W-1:0]    width_q, height_q;
  logic [ColW-1:0]     col_q, col_d;
  logic [RowW-1:0]     row_q, row_d;
  logic [PIX_W-1:0]    held_q;
  logic [PAIR_W-1:0]   line_mem [LineDepth];
  logic [PAIR_W-1:0]   line_rd_q;

  logic [EffWW-1:0]    w_eff;
  logic [EffHW-1:0]    h_eff;
  logic                accept, col_end, row_end, cfg_hit;
  logic                blk_col_end, blk_row_end;
  logic                line_wr, line_rd;
  logic [LineAw-1:0]   line_addr;
  logic [PAIR_W-1:0]   pair;
  logic [PAIR_W:0]     quad;
  logic [ColW:0]       col2;
  logic [RowW:0]       row2;

  always_comb begin
    if (width_q == '0) begin
      w_eff = EffWW'(1);
    end else if (CmpWW'(width_q) > CmpWW'(MAX_WIDTH)) begin
      w_eff = EffWW'(MAX_WIDTH);
    end else begin
      w_eff = EffWW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = EffHW'(1);
    end else if (CmpHW'(height_q) > CmpHW'(MAX_HEIGHT)) begin
      h_eff = EffHW'(MAX_HEIGHT);
    end else begin
      h_eff = EffHW'(height_q);
    end
  end

  assign accept      = push_i && !q_full_i;
  assign col_end     = (EffWW'(col_q) + EffWW'(1)) == w_eff;
  assign row_end     = (EffHW'(row_q) + EffHW'(1)) == h_eff;
  assign blk_col_end = (EffWW'(col_q >> 1) + EffWW'(1)) == (w_eff >> 1);
  assign blk_row_end = (EffHW'(row_q >> 1) + EffHW'(1)) == (h_eff >> 1);
  assign cfg_hit     = cfg_we_i && (cfg_idx_i == REG_SCALE_MODE ||
                                    cfg_idx_i == REG_IMAGE_WIDTH ||
                                    cfg_idx_i == REG_IMAGE_HEIGHT);

  assign line_addr = LineAw'(col_q >> 1);
  assign pair      = PAIR_W'(held_q) + PAIR_W'(pixel_in_i);
  assign quad      = (PAIR_W+1)'(line_rd_q) + (PAIR_W+1)'(pair);
  assign line_rd   = accept && (mode_q == MODE_DOWN) && !col_q[0];
  assign line_wr   = accept && (mode_q == MODE_DOWN) && col_q[0] && !row_q[0] && !row_end;
  assign col2      = {col_q, 1'b0};
  assign row2      = {row_q, 1'b0};

  always_comb begin
    q_push_o = 1'b0;
    q_cmd_o  = '0;
    if (mode_q == MODE_UP) begin
      q_push_o      = accept;
      q_cmd_o.mode  = MODE_UP;
      q_cmd_o.pixel = pixel_in_i;
      q_cmd_o.row   = COORD_W'(row2);
      q_cmd_o.col   = COORD_W'(col2);
      q_cmd_o.last  = row_end && col_end;
    end else begin
      q_push_o      = accept && col_q[0] && row_q[0];
      q_cmd_o.mode  = MODE_DOWN;
      q_cmd_o.pixel = quad[PAIR_W:2];
      q_cmd_o.row   = COORD_W'(row_q >> 1);
      q_cmd_o.col   = COORD_W'(col_q >> 1);
      q_cmd_o.last  = blk_row_end && blk_col_end;
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_UP;
      width_q  <= CFG_W'(1024);
      height_q <= CFG_W'(1024);
      col_q    <= '0;
      row_q    <= '0;
      held_q   <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SCALE_MODE:   mode_q   <= isb_mode_e'(cfg_data_i[0]);
          REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
          REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (line_rd) begin
        held_q <= pixel_in_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_wr) begin
      line_mem[line_addr] <= pair;
    end
    if (line_rd) begin
      line_rd_q <= line_mem[line_addr];
    end
  end

endmodule

// ===== sv/isb_back.sv =====
// -----------------------------------------------------------------------------
// Image scale by two: back
// Expands each command word into its result words behind an output register.
// -----------------------------------------------------------------------------
module isb_back import isb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  isb_cmd_t           q_cmd_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output logic [PIX_W-1:0]   pixel_out_o,
  output logic [COORD_W-1:0] out_row_o,
  output logic [COORD_W-1:0] out_col_o,
  output logic               run_last_o,
  output logic               frame_last_o
);

  logic [1:0]         sub_q, sub_d;
  logic               vld_q;
  logic [PIX_W-1:0]   pix_q;
  logic [COORD_W-1:0] row_q, col_q, row_d, col_d;
  logic               run_q, frame_q;
  logic               adv, load, final_word, is_up;

  assign is_up      = (q_cmd_i.mode == MODE_UP);
  assign adv        = !vld_q || pop_i;
  assign load       = adv && !q_empty_i;
  assign final_word = !is_up || (sub_q == 2'd3);
  assign q_pop_o    = load && final_word;

  always_comb begin
    sub_d = sub_q;
    if (load) begin
      sub_d = final_word ? 2'd0 : sub_q + 2'd1;
    end
    row_d = q_cmd_i.row | {{(COORD_W-1){1'b0}}, is_up & sub_q[1]};
    col_d = q_cmd_i.col | {{(COORD_W-1){1'b0}}, is_up & sub_q[0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      sub_q <= sub_d;
      if (adv) begin
        vld_q <= !q_empty_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q   <= q_cmd_i.pixel;
      row_q   <= row_d;
      col_q   <= col_d;
      run_q   <= final_word;
      frame_q <= final_word && q_cmd_i.last;
    end
  end

  assign empty_o      = !vld_q;
  assign pixel_out_o  = pix_q;
  assign out_row_o    = row_q;
  assign out_col_o    = col_q;
  assign run_last_o   = run_q;
  assign frame_last_o = frame_q;

endmodule

// ===== sv/image_scale_by_two.sv =====
// -----------------------------------------------------------------------------
// Image scale by two: top level
// Nearest-neighbor 2x upscale or 2x2 box-average downscale of a grey image.
// -----------------------------------------------------------------------------
// Pixels enter in raster order, one word per push. In upscale mode each pixel
// yields four result words; the output register gives one result word per cycle
// while pop is held high, so a full command queue stalls intake. In downscale
// mode only a full queue holds intake, and results appear at odd-row, odd-column
// pixels. A two-entry command queue separates pixel intake from result
// expansion. The pair-sum line buffer needs no clearing after reset: every
// entry is written on an even row before the following odd row reads it. Any
// configuration write to a known register restarts at row and column zero.
module image_scale_by_two import isb_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 push,
  output logic                 full,
  input  logic [PIX_W-1:0]     pixel_in_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [PIX_W-1:0]     pixel_out_o,
  output logic [COORD_W-1:0]   out_row_o,
  output logic [COORD_W-1:0]   out_col_o,
  output logic                 run_last_o,
  output logic                 frame_last_o
);

`include "image_scale_by_two_defines.svh"

  isb_cmd_t q_in_cmd, q_out_cmd;
  logic     q_push, q_full, q_pop, q_empty;

  assign full = q_full;

  isb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .pixel_in_i (pixel_in_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_in_cmd)
  );

  isb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out_cmd),
    .empty_o (q_empty)
  );

  isb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_cmd_i      (q_out_cmd),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .pixel_out_o  (pixel_out_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .run_last_o   (run_last_o),
    .frame_last_o (frame_last_o)
  );

  `ISB_ASSERT_ALWAYS(a_empty_in_reset, !rst_ni |=> empty, "result visible during reset")
  `ISB_ASSERT(a_frame_ends_run, !empty && frame_last_o |-> run_last_o, "frame end mid-run")
  `ISB_ASSERT(a_no_overflow, q_push |-> !q_full, "command queue overflow")
  `ISB_ASSERT(a_no_underflow, q_pop |-> !q_empty, "command queue underflow")

endmodule
